/* rtl/core/assert_macros.svh */
// Assertion macros shared by the serial mouse packet decoder RTL.
// Depends on nothing; included by every module that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at each rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at each rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* rtl/core/smpd_pkg.sv */
// Types and constants shared by the serial mouse packet decoder modules.
// Depends on nothing.
package smpd_pkg;

   typedef enum logic [1:0] {
      PHASE_HEADER,
      PHASE_X,
      PHASE_Y
   } smpd_phase_type;

   localparam logic [2:0] KIND_X      = 3'd0;
   localparam logic [2:0] KIND_Y      = 3'd1;
   localparam logic [2:0] KIND_LEFT   = 3'd2;
   localparam logic [2:0] KIND_MIDDLE = 3'd3;
   localparam logic [2:0] KIND_RIGHT  = 3'd4;

   localparam logic [6:0] MIDDLE_MASK = 7'h23;

   localparam int JOB_X     = 0;
   localparam int JOB_Y     = 1;
   localparam int JOB_RIGHT = 2;
   localparam int JOB_LEFT  = 3;
   localparam int JOB_MID   = 4;
   localparam int JOB_BITS  = 5;

   // One decoded byte: the events still to emit and their values.
   typedef struct packed {
      logic [JOB_BITS-1:0] pend;
      logic [7:0]          x_val;
      logic [7:0]          y_val;
      logic                right_val;
      logic                left_val;
      logic                mid_val;
   } smpd_job_type;

endpackage

/* rtl/core/smpd_front.sv */
// Front end: accepts bytes, tracks packet state and classifies each byte
// into a job of pending events. Depends on smpd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module smpd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic                  csr_write_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [6:0]            req_rx_byte,
   input  logic                  q_ready,
   output logic                  q_push,
   output smpd_pkg::smpd_job_type q_data
);

   logic                     enabled_ff, enabled_in;
   smpd_pkg::smpd_phase_type phase_ff, phase_in;
   logic [6:0]               header_ff, header_in;
   logic [7:0]               held_x_ff, held_x_in;
   logic [1:0]               buttons_ff, buttons_in;
   logic                     accept;
   logic [7:0]               dy;
   smpd_pkg::smpd_job_type   job;

   assign req_ready = q_ready;
   assign accept    = req_valid && q_ready;
   assign dy        = {header_ff[3:2], req_rx_byte[5:0]};

   always_comb begin
      enabled_in = csr_write_enable ? csr_write_data : enabled_ff;
      phase_in   = phase_ff;
      header_in  = header_ff;
      held_x_in  = held_x_ff;
      buttons_in = buttons_ff;
      job        = '0;
      job.x_val  = held_x_ff;
      job.y_val  = dy;
      job.right_val = header_ff[4];
      job.left_val  = header_ff[5];
      job.mid_val   = req_rx_byte[5];
      if (accept && enabled_ff) begin
         if (req_rx_byte[6]) begin
            header_in = req_rx_byte;
            phase_in  = smpd_pkg::PHASE_X;
         end else begin
            unique case (phase_ff)
               smpd_pkg::PHASE_HEADER: begin
                  if ((req_rx_byte & ~smpd_pkg::MIDDLE_MASK) == 7'd0) begin
                     job.pend[smpd_pkg::JOB_MID] = 1'b1;
                  end
               end
               smpd_pkg::PHASE_X: begin
                  held_x_in = {header_ff[1:0], req_rx_byte[5:0]};
                  phase_in  = smpd_pkg::PHASE_Y;
               end
               default: begin
                  job.pend[smpd_pkg::JOB_X]     = (held_x_ff != 8'd0);
                  job.pend[smpd_pkg::JOB_Y]     = (dy != 8'd0);
                  job.pend[smpd_pkg::JOB_RIGHT] = (header_ff[4] != buttons_ff[0]);
                  job.pend[smpd_pkg::JOB_LEFT]  = (header_ff[5] != buttons_ff[1]);
                  buttons_in = {header_ff[5], header_ff[4]};
                  phase_in   = smpd_pkg::PHASE_HEADER;
               end
            endcase
         end
      end
   end

   assign q_push = accept && (job.pend != '0);
   assign q_data = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b1;
         phase_ff   <= smpd_pkg::PHASE_HEADER;
         header_ff  <= 7'd0;
         held_x_ff  <= 8'd0;
         buttons_ff <= 2'd0;
      end else begin
         enabled_ff <= enabled_in;
         phase_ff   <= phase_in;
         header_ff  <= header_in;
         held_x_ff  <= held_x_in;
         buttons_ff <= buttons_in;
      end
   end

   `ASSERT_NEXT(a_header_opens_packet, clock, reset,
      accept && enabled_ff && req_rx_byte[6], phase_ff == smpd_pkg::PHASE_X)
   `ASSERT_IMPLY(a_push_needs_enable, clock, reset, q_push, enabled_ff && accept)

endmodule

/* rtl/core/smpd_queue.sv */
// Short job queue between the front end and the event emitter.
// Depends on smpd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module smpd_queue #(
   parameter int DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  smpd_pkg::smpd_job_type push_data,
   output logic                   push_ready,
   input  logic                   pop,
   output logic                   pop_valid,
   output smpd_pkg::smpd_job_type pop_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   smpd_pkg::smpd_job_type mem [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_data   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `ASSERT_IMPLY(a_count_bounded, clock, reset, 1'b1, count_ff <= FULL_CNT)
   `ASSERT_NEXT(a_push_counts, clock, reset, do_push && !do_pop,
      count_ff == $past(count_ff) + 1'b1)

endmodule

/* rtl/core/smpd_back.sv */
// Back end: takes jobs from the queue and emits their events one per cycle
// while rsp is ready, via an output register. Depends on smpd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module smpd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  smpd_pkg::smpd_job_type q_data,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_event_kind,
   output logic signed [7:0]      rsp_event_value,
   output logic                   rsp_last
);

   smpd_pkg::smpd_job_type job_ff, job_in;
   logic                   valid_ff, valid_in;
   logic [2:0]             kind_ff, kind_in;
   logic [7:0]             value_ff, value_in;
   logic                   last_ff, last_in;
   logic                   out_free;
   logic                   active;
   logic [smpd_pkg::JOB_BITS-1:0] rest;

   assign out_free = !valid_ff || rsp_ready;
   assign active   = (job_ff.pend != '0);

   always_comb begin
      job_in   = job_ff;
      valid_in = valid_ff;
      kind_in  = kind_ff;
      value_in = value_ff;
      last_in  = last_ff;
      q_pop    = 1'b0;
      rest     = job_ff.pend;
      if (out_free) begin
         valid_in = 1'b0;
         if (active) begin
            if (job_ff.pend[smpd_pkg::JOB_X]) begin
               kind_in  = smpd_pkg::KIND_X;
               value_in = job_ff.x_val;
               rest[smpd_pkg::JOB_X] = 1'b0;
            end else if (job_ff.pend[smpd_pkg::JOB_Y]) begin
               kind_in  = smpd_pkg::KIND_Y;
               value_in = job_ff.y_val;
               rest[smpd_pkg::JOB_Y] = 1'b0;
            end else if (job_ff.pend[smpd_pkg::JOB_RIGHT]) begin
               kind_in  = smpd_pkg::KIND_RIGHT;
               value_in = {7'd0, job_ff.right_val};
               rest[smpd_pkg::JOB_RIGHT] = 1'b0;
            end else if (job_ff.pend[smpd_pkg::JOB_LEFT]) begin
               kind_in  = smpd_pkg::KIND_LEFT;
               value_in = {7'd0, job_ff.left_val};
               rest[smpd_pkg::JOB_LEFT] = 1'b0;
            end else begin
               kind_in  = smpd_pkg::KIND_MIDDLE;
               value_in = {7'd0, job_ff.mid_val};
               rest[smpd_pkg::JOB_MID] = 1'b0;
            end
            valid_in    = 1'b1;
            last_in     = (rest == '0);
            job_in.pend = rest;
            if (rest == '0 && q_valid) begin
               q_pop  = 1'b1;
               job_in = q_data;
            end
         end
      end
      if (!active && q_valid) begin
         q_pop  = 1'b1;
         job_in = q_data;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      value_ff <= value_in;
      last_ff  <= last_in;
      job_ff.x_val     <= job_in.x_val;
      job_ff.y_val     <= job_in.y_val;
      job_ff.right_val <= job_in.right_val;
      job_ff.left_val  <= job_in.left_val;
      job_ff.mid_val   <= job_in.mid_val;
      if (reset) begin
         valid_ff    <= 1'b0;
         job_ff.pend <= '0;
      end else begin
         valid_ff    <= valid_in;
         job_ff.pend <= job_in.pend;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_event_kind  = kind_ff;
   assign rsp_event_value = value_ff;
   assign rsp_last        = last_ff;

   `ASSERT_IMPLY(a_more_events_pending, clock, reset, valid_ff && !last_ff, active)
   `ASSERT_IMPLY(a_pop_only_when_free, clock, reset, q_pop, !active || out_free)

endmodule

/* rtl/core/serial_mouse_packet_decoder_core.sv */
// Top level of the serial mouse packet decoder.
// Depends on smpd_pkg, smpd_front, smpd_queue and smpd_back.
//
// The req channel carries one 7-bit serial mouse byte per item; the rsp
// channel carries one event per item (kind, signed value, last flag).
// Both use valid and ready. csr_write_enable writes the enable bit from
// csr_write_data at once; while it is clear, bytes are taken and dropped.
// A header byte (bit 6 set) opens a three-byte packet; the third byte
// yields up to four events in the order X, Y, right, left. A lone byte
// with only bits of 0x23 set yields one middle-button event.
// The first event of a byte is valid once it has passed the queue entry,
// the emitter's job register and its output register. The emitter sends
// one event per cycle while rsp is ready, so a byte yields zero to four
// events. Only the last byte of a packet yields more than one event; the
// queue lets new bytes in while earlier events are still being sent.
// The front end accepts a byte each cycle while the job queue
// (QUEUE_DEPTH entries) has room, so bytes keep flowing while rsp stalls
// until the queue fills; req_ready then drops.
// Reset is synchronous: the enable bit sets, packet state and button
// state clear, and the queue and output register empty.
module serial_mouse_packet_decoder_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic              csr_write_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [6:0]        req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_event_kind,
   output logic signed [7:0] rsp_event_value,
   output logic              rsp_last
);

   smpd_pkg::smpd_job_type push_data, pop_data;
   logic push, push_ready, pop, pop_valid;

   smpd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .q_ready          (push_ready),
      .q_push           (push),
      .q_data           (push_data)
   );

   smpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data)
   );

   smpd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (pop_valid),
      .q_data          (pop_data),
      .q_pop           (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_event_value (rsp_event_value),
      .rsp_last        (rsp_last)
   );

endmodule
